FILE: rtl/pgf_pkg.sv
// shared types and constants of the four-neighbour gap filler
package pgf_pkg;

  localparam int MaxSide   = 64;
  localparam int PixelBits = 8;
  localparam int ColW      = $clog2(MaxSide);
  localparam int SideW     = 7;
  localparam int RowW      = $clog2(MaxSide + 1);
  localparam int OnesW     = 3;

  localparam logic [SideW-1:0] SideReset = SideW'(8);
  localparam logic [OnesW-1:0] OnesNeed  = OnesW'(3);

  typedef logic [PixelBits-1:0] pix_t;
  typedef logic [ColW-1:0]      col_t;
  typedef logic [RowW-1:0]      row_t;
  typedef logic [SideW-1:0]     side_t;

  localparam pix_t PixOne  = pix_t'(1);
  localparam pix_t PixZero = '0;

  // one line store word: row before last and last row at one column
  typedef struct packed {
    pix_t upper;
    pix_t centre;
  } line_entry_t;

  // position of the next item in the raster
  typedef struct packed {
    col_t col;
    logic top;
    logic bottom;
    logic lft;
    logic rgt;
    logic produce;
  } pos_t;

  typedef struct packed {
    logic        en;
    col_t        addr;
    line_entry_t data;
  } line_wr_t;

  // context of the item waiting on its line store read
  typedef struct packed {
    pos_t pos;
    pix_t below;
  } fill_ctx_t;

endpackage

FILE: rtl/pgf_if.sv
// valid/ready stream interfaces of the gap filler
interface pgf_in_if;
  logic          valid;
  logic          ready;
  logic          kind;
  pgf_pkg::pix_t pixel;

  modport source (output valid, kind, pixel, input ready);
  modport sink   (input valid, kind, pixel, output ready);
endinterface

interface pgf_out_if;
  logic          valid;
  logic          ready;
  pgf_pkg::pix_t filled_pixel;
  logic          end_of_row;
  logic          last;

  modport source (output valid, filled_pixel, end_of_row, last, input ready);
  modport sink   (input valid, filled_pixel, end_of_row, last, output ready);
endinterface

FILE: rtl/pgf_line_mem.sv
// two-row line store with registered reads and write forwarding
module pgf_line_mem (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  pgf_pkg::col_t        rd_addr0_i,
  input  pgf_pkg::col_t        rd_addr1_i,
  input  pgf_pkg::line_wr_t    wr_i,
  output pgf_pkg::line_entry_t rd_data0_o,
  output pgf_pkg::line_entry_t rd_data1_o
);

  pgf_pkg::line_entry_t mem_q [pgf_pkg::MaxSide];
  pgf_pkg::line_entry_t rd0_q, rd1_q, fwd_data_q;
  logic                 fwd0_q, fwd1_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd0_q      <= mem_q[rd_addr0_i];
      rd1_q      <= mem_q[rd_addr1_i];
      fwd0_q     <= wr_i.en && (wr_i.addr == rd_addr0_i);
      fwd1_q     <= wr_i.en && (wr_i.addr == rd_addr1_i);
      fwd_data_q <= wr_i.data;
    end
  end

  assign rd_data0_o = fwd0_q ? fwd_data_q : rd0_q;
  assign rd_data1_o = fwd1_q ? fwd_data_q : rd1_q;

endmodule

FILE: rtl/pgf_raster_cnt.sv
// side register and column/row counters of the input raster
module pgf_raster_cnt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  pgf_pkg::side_t      cfg_wdata_i,
  input  logic                adv_i,
  output pgf_pkg::pos_t       pos_o
);

  pgf_pkg::side_t side_q;
  pgf_pkg::col_t  col_q, col_d;
  pgf_pkg::row_t  row_q, row_d;
  pgf_pkg::row_t  n;
  pgf_pkg::col_t  n_m1;

  always_comb begin
    if (side_q == '0) begin
      n = pgf_pkg::RowW'(1);
    end else if (pgf_pkg::RowW'(side_q) > pgf_pkg::RowW'(pgf_pkg::MaxSide)) begin
      n = pgf_pkg::RowW'(pgf_pkg::MaxSide);
    end else begin
      n = pgf_pkg::RowW'(side_q);
    end
    n_m1 = pgf_pkg::ColW'(n - pgf_pkg::RowW'(1));
  end

  always_comb begin
    pos_o.col     = col_q;
    pos_o.top     = (row_q == pgf_pkg::RowW'(1));
    pos_o.bottom  = (row_q == n);
    pos_o.lft     = (col_q == '0);
    pos_o.rgt     = (col_q == n_m1);
    pos_o.produce = (row_q != '0);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (adv_i) begin
      if (pos_o.rgt) begin
        col_d = '0;
        row_d = pos_o.bottom ? '0 : row_q + pgf_pkg::RowW'(1);
      end else begin
        col_d = col_q + pgf_pkg::ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= pgf_pkg::SideReset;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        side_q <= cfg_wdata_i;
      end
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

FILE: rtl/pgf_fill_stage.sv
// fill decision, line store write-back and output register
module pgf_fill_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  pgf_pkg::fill_ctx_t   ctx_i,
  input  pgf_pkg::line_entry_t rd_data0_i,
  input  pgf_pkg::line_entry_t rd_data1_i,
  output logic                 take_o,
  output pgf_pkg::line_wr_t    wr_o,
  pgf_out_if.source            out_o
);

  pgf_pkg::fill_ctx_t s1_q;
  logic               s1_valid_q, s1_valid_d;
  logic               s1_adv, s1_fire;
  pgf_pkg::pix_t      prev_centre_q;
  pgf_pkg::pix_t      upper, centre, right, res;
  logic [pgf_pkg::OnesW-1:0] ones;
  logic               out_valid_q, out_valid_d;
  pgf_pkg::pix_t      out_pix_q;
  logic               out_eor_q, out_last_q;

  assign upper  = rd_data0_i.upper;
  assign centre = rd_data0_i.centre;
  assign right  = rd_data1_i.centre;

  always_comb begin
    ones = '0;
    if (!s1_q.pos.top    && upper         == pgf_pkg::PixOne) ones++;
    if (!s1_q.pos.bottom && s1_q.below    == pgf_pkg::PixOne) ones++;
    if (!s1_q.pos.lft    && prev_centre_q == pgf_pkg::PixOne) ones++;
    if (!s1_q.pos.rgt    && right         == pgf_pkg::PixOne) ones++;
    if (centre != pgf_pkg::PixZero) begin
      res = centre;
    end else if ((s1_q.pos.top || s1_q.pos.bottom) && (s1_q.pos.lft || s1_q.pos.rgt)) begin
      res = pgf_pkg::PixZero;
    end else begin
      res = (ones >= pgf_pkg::OnesNeed) ? pgf_pkg::PixOne : pgf_pkg::PixZero;
    end
  end

  assign s1_adv  = !s1_q.pos.produce || !out_valid_q || out_o.ready;
  assign s1_fire = s1_valid_q && s1_adv;
  assign take_o  = !s1_valid_q || s1_adv;

  always_comb begin
    wr_o.en          = s1_fire;
    wr_o.addr        = s1_q.pos.col;
    wr_o.data.upper  = centre;
    wr_o.data.centre = s1_q.below;
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (load_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_fire && s1_q.pos.produce) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_q <= ctx_i;
    end
    if (s1_fire) begin
      prev_centre_q <= centre;
    end
    if (s1_fire && s1_q.pos.produce) begin
      out_pix_q  <= res;
      out_eor_q  <= s1_q.pos.rgt;
      out_last_q <= s1_q.pos.bottom && s1_q.pos.rgt;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.filled_pixel = out_pix_q;
  assign out_o.end_of_row   = out_eor_q;
  assign out_o.last         = out_last_q;

endmodule

FILE: rtl/pixel_gap_fill_4_neighbour.sv
// top level of the four-neighbour gap filler
//
//   port    dir  handshake       payload
//   in_i    in   valid/ready     kind, pixel
//   out_o   out  valid/ready     filled_pixel, end_of_row, last
//   cfg     in   cfg_we_i        cfg_wdata_i (side)
//
// one item per cycle while the output is not held; each item passes to its result register
// through the line store read, then the decision and write-back
// results trail their input by one row; side flush items drain the last row
// reset clears counters and valid flags and restores the side register only, the line store is not cleared
// a held result blocks one further item, then input stalls
module pixel_gap_fill_4_neighbour (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  pgf_pkg::side_t cfg_wdata_i,
  pgf_in_if.sink         in_i,
  pgf_out_if.source      out_o
);

  logic                 in_fire, take;
  pgf_pkg::pos_t        pos;
  pgf_pkg::fill_ctx_t   ctx;
  pgf_pkg::line_wr_t    wr;
  pgf_pkg::line_entry_t rd_data0, rd_data1;

  assign in_i.ready = take;
  assign in_fire    = in_i.valid && take;

  always_comb begin
    ctx.pos   = pos;
    ctx.below = pos.bottom ? pgf_pkg::PixZero : in_i.pixel;
  end

  pgf_raster_cnt u_cnt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .adv_i       (in_fire),
    .pos_o       (pos)
  );

  pgf_line_mem u_mem (
    .clk_i      (clk_i),
    .rd_en_i    (in_fire),
    .rd_addr0_i (pos.col),
    .rd_addr1_i (pos.col + pgf_pkg::ColW'(1)),
    .wr_i       (wr),
    .rd_data0_o (rd_data0),
    .rd_data1_o (rd_data1)
  );

  pgf_fill_stage u_fill (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_fire),
    .ctx_i      (ctx),
    .rd_data0_i (rd_data0),
    .rd_data1_i (rd_data1),
    .take_o     (take),
    .wr_o       (wr),
    .out_o      (out_o)
  );

endmodule

FILE: rtl/pgf_checker.sv
// port-level checks of the gap filler and their binding
module pgf_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input pgf_pkg::pix_t out_filled_pixel_i,
  input logic          out_end_of_row_i,
  input logic          out_last_i
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_i;

  // a stalled item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_filled_pixel_i)
      && $stable(out_end_of_row_i) && $stable(out_last_i))
    else $error("stalled output item changed");

  // frame end is always a row end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_last_i |-> out_end_of_row_i)
    else $error("last without end_of_row");

  // a fresh result must trace back to an accepted input item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_fire, 2))
    else $error("output appeared without input item");

endmodule

bind pixel_gap_fill_4_neighbour pgf_checker u_pgf_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_filled_pixel_i (out_o.filled_pixel),
  .out_end_of_row_i   (out_o.end_of_row),
  .out_last_i         (out_o.last)
);
